// ===== hdl/motor_command_frame_builder_defines.svh =====
// Assertion macros used by the frame builder RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef MOTOR_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame builder check failed");

// Next-cycle implication, disabled during reset.
`define MCFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame builder check failed");

`endif

// ===== hdl/mcfb_pkg.sv =====
// Package for the motor command frame builder: codes, widths and the
// records passed between the front end, the request queue and the serializer.
`timescale 1ns / 1ps

package mcfb_pkg;

   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 5;
   localparam int MAX_BODY = 8;   // bytes in front of the checksum, at most
   localparam int COUNT_W  = 4;   // holds 0 .. MAX_BODY
   localparam int SUM_W    = 11;  // MAX_BODY * 255 fits without wrapping

   typedef enum logic [1:0] {
      ACT_SET_REG   = 2'd0,
      ACT_GET_REG   = 2'd1,
      ACT_EXECUTE   = 2'd2,
      ACT_EXEC_RAMP = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SIZE_ONE     = 2'd0,
      SIZE_TWO     = 2'd1,
      SIZE_FOUR    = 2'd2,
      SIZE_INVALID = 2'd3
   } value_size_type;

   typedef enum logic [1:0] {
      CSR_CODE_SET  = 2'd0,
      CSR_CODE_GET  = 2'd1,
      CSR_CODE_EXEC = 2'd2,
      CSR_CODE_RAMP = 2'd3
   } csr_index_type;

   localparam logic [CODE_W-1:0] RESET_CODE_SET  = 5'd1;
   localparam logic [CODE_W-1:0] RESET_CODE_GET  = 5'd2;
   localparam logic [CODE_W-1:0] RESET_CODE_EXEC = 5'd3;
   localparam logic [CODE_W-1:0] RESET_CODE_RAMP = 5'd7;

   localparam logic [BYTE_W-1:0] LEN_SET_ONE  = 8'd2;
   localparam logic [BYTE_W-1:0] LEN_SET_TWO  = 8'd3;
   localparam logic [BYTE_W-1:0] LEN_SET_FOUR = 8'd5;
   localparam logic [BYTE_W-1:0] LEN_ID_ONLY  = 8'h01;
   localparam logic [BYTE_W-1:0] LEN_RAMP     = 8'h06;

   localparam logic [COUNT_W-1:0] CNT_SET_ONE  = 4'd4;
   localparam logic [COUNT_W-1:0] CNT_SET_TWO  = 4'd5;
   localparam logic [COUNT_W-1:0] CNT_SET_FOUR = 4'd7;
   localparam logic [COUNT_W-1:0] CNT_ID_ONLY  = 4'd3;
   localparam logic [COUNT_W-1:0] CNT_RAMP     = 4'd8;

   // One classified request: frame bytes ahead of the checksum.
   typedef struct packed {
      logic [MAX_BODY-1:0][BYTE_W-1:0] bytes;
      logic [COUNT_W-1:0]              count;
      logic                            size_error;
   } frame_desc_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              last_byte;
      logic              size_error;
   } rsp_item_type;

endpackage

// ===== hdl/motor_command_frame_builder.sv =====
// Motor command frame builder, top level. Each request becomes one serial
// frame of 4 to 9 bytes (9 for an execute ramp), or one error result for a
// bad value size; results leave one byte per cycle while the consumer pops.
// The serializer emits one byte per clock while the result buffer has room;
// frames follow each other with no gap. Up to two classified requests wait
// between the front end and the serializer, and a two-entry result buffer
// lets the serializer continue while the consumer stalls. Command code
// registers are written through the csr_ port, which is always ready.
// Depends on mcfb_pkg and the mcfb_ modules.
`timescale 1ns / 1ps

module motor_command_frame_builder (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [4:0]          csr_wdata,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_action,
   input  logic [2:0]          req_motor_id,
   input  logic [7:0]          req_item_id,
   input  logic [1:0]          req_value_size,
   input  logic signed [31:0]  req_value,
   input  logic [15:0]         req_duration,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last_byte,
   output logic                rsp_size_error
);

   mcfb_pkg::frame_desc_type new_desc;
   mcfb_pkg::frame_desc_type head_desc;
   logic                     req_fire;
   logic                     desc_empty;
   logic                     desc_pop;

   assign csr_ready = 1'b1;
   assign req_fire  = req_push & ~req_full;

   mcfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr         (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_action     (req_action),
      .req_motor_id   (req_motor_id),
      .req_item_id    (req_item_id),
      .req_value_size (req_value_size),
      .req_value      (req_value),
      .req_duration   (req_duration),
      .desc           (new_desc)
   );

   mcfb_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_desc (new_desc),
      .full      (req_full),
      .pop       (desc_pop),
      .head_desc (head_desc),
      .empty     (desc_empty)
   );

   mcfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_desc      (head_desc),
      .desc_empty     (desc_empty),
      .desc_pop       (desc_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_size_error (rsp_size_error)
   );

endmodule

// ===== hdl/mcfb_front.sv =====
// Front end of the frame builder: command code registers and request
// classification into a frame record. Depends on mcfb_pkg.
`timescale 1ns / 1ps

module mcfb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr,
   input  logic [1:0]                     csr_index,
   input  logic [mcfb_pkg::CODE_W-1:0]    csr_wdata,
   input  logic [1:0]                     req_action,
   input  logic [2:0]                     req_motor_id,
   input  logic [7:0]                     req_item_id,
   input  logic [1:0]                     req_value_size,
   input  logic signed [31:0]             req_value,
   input  logic [15:0]                    req_duration,
   output mcfb_pkg::frame_desc_type       desc
);

   logic [mcfb_pkg::CODE_W-1:0] code_set_ff,  code_set_in;
   logic [mcfb_pkg::CODE_W-1:0] code_get_ff,  code_get_in;
   logic [mcfb_pkg::CODE_W-1:0] code_exec_ff, code_exec_in;
   logic [mcfb_pkg::CODE_W-1:0] code_ramp_ff, code_ramp_in;

   always_comb begin
      code_set_in  = code_set_ff;
      code_get_in  = code_get_ff;
      code_exec_in = code_exec_ff;
      code_ramp_in = code_ramp_ff;
      if (csr_wr) begin
         case (mcfb_pkg::csr_index_type'(csr_index))
            mcfb_pkg::CSR_CODE_SET:  code_set_in  = csr_wdata;
            mcfb_pkg::CSR_CODE_GET:  code_get_in  = csr_wdata;
            mcfb_pkg::CSR_CODE_EXEC: code_exec_in = csr_wdata;
            mcfb_pkg::CSR_CODE_RAMP: code_ramp_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_set_ff  <= mcfb_pkg::RESET_CODE_SET;
         code_get_ff  <= mcfb_pkg::RESET_CODE_GET;
         code_exec_ff <= mcfb_pkg::RESET_CODE_EXEC;
         code_ramp_ff <= mcfb_pkg::RESET_CODE_RAMP;
      end else begin
         code_set_ff  <= code_set_in;
         code_get_ff  <= code_get_in;
         code_exec_ff <= code_exec_in;
         code_ramp_ff <= code_ramp_in;
      end
   end

   // Payload bytes go out little-endian.
   always_comb begin
      desc = '0;
      case (mcfb_pkg::action_type'(req_action))
         mcfb_pkg::ACT_SET_REG: begin
            desc.bytes[0] = {req_motor_id, code_set_ff};
            desc.bytes[2] = req_item_id;
            desc.bytes[3] = req_value[7:0];
            case (mcfb_pkg::value_size_type'(req_value_size))
               mcfb_pkg::SIZE_ONE: begin
                  desc.bytes[1] = mcfb_pkg::LEN_SET_ONE;
                  desc.count    = mcfb_pkg::CNT_SET_ONE;
               end
               mcfb_pkg::SIZE_TWO: begin
                  desc.bytes[1] = mcfb_pkg::LEN_SET_TWO;
                  desc.bytes[4] = req_value[15:8];
                  desc.count    = mcfb_pkg::CNT_SET_TWO;
               end
               mcfb_pkg::SIZE_FOUR: begin
                  desc.bytes[1] = mcfb_pkg::LEN_SET_FOUR;
                  desc.bytes[4] = req_value[15:8];
                  desc.bytes[5] = req_value[23:16];
                  desc.bytes[6] = req_value[31:24];
                  desc.count    = mcfb_pkg::CNT_SET_FOUR;
               end
               default: begin
                  desc.size_error = 1'b1;
               end
            endcase
         end
         mcfb_pkg::ACT_GET_REG: begin
            desc.bytes[0] = {req_motor_id, code_get_ff};
            desc.bytes[1] = mcfb_pkg::LEN_ID_ONLY;
            desc.bytes[2] = req_item_id;
            desc.count    = mcfb_pkg::CNT_ID_ONLY;
         end
         mcfb_pkg::ACT_EXECUTE: begin
            desc.bytes[0] = {req_motor_id, code_exec_ff};
            desc.bytes[1] = mcfb_pkg::LEN_ID_ONLY;
            desc.bytes[2] = req_item_id;
            desc.count    = mcfb_pkg::CNT_ID_ONLY;
         end
         default: begin
            desc.bytes[0] = {req_motor_id, code_ramp_ff};
            desc.bytes[1] = mcfb_pkg::LEN_RAMP;
            desc.bytes[2] = req_value[7:0];
            desc.bytes[3] = req_value[15:8];
            desc.bytes[4] = req_value[23:16];
            desc.bytes[5] = req_value[31:24];
            desc.bytes[6] = req_duration[7:0];
            desc.bytes[7] = req_duration[15:8];
            desc.count    = mcfb_pkg::CNT_RAMP;
         end
      endcase
   end

endmodule

// ===== hdl/mcfb_desc_queue.sv =====
// Two-entry queue of classified requests between the front end and the
// serializer. Depends on mcfb_pkg.
`timescale 1ns / 1ps

module mcfb_desc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mcfb_pkg::frame_desc_type push_desc,
   output logic                     full,
   input  logic                     pop,
   output mcfb_pkg::frame_desc_type head_desc,
   output logic                     empty
);

   mcfb_pkg::frame_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign empty     = (cnt_ff == 2'd0);
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== hdl/mcfb_back.sv =====
// Serializer of the frame builder: walks the head request byte by byte,
// builds the checksum on the fly and feeds a two-entry result buffer.
// Depends on mcfb_pkg and motor_command_frame_builder_defines.svh.
`timescale 1ns / 1ps
`include "motor_command_frame_builder_defines.svh"

module mcfb_back (
   input  logic                               clock,
   input  logic                               reset,
   input  mcfb_pkg::frame_desc_type           head_desc,
   input  logic                               desc_empty,
   output logic                               desc_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [mcfb_pkg::BYTE_W-1:0]        rsp_frame_byte,
   output logic                               rsp_last_byte,
   output logic                               rsp_size_error
);

   logic [mcfb_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic [mcfb_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [mcfb_pkg::BYTE_W-1:0]  checksum;
   logic                         is_chk;
   logic                         rsp_fire;
   logic                         can_emit;
   logic                         emit_fire;
   mcfb_pkg::rsp_item_type       emit_item;

   mcfb_pkg::rsp_item_type out_ff [2];
   logic       out_wr_ff, out_wr_in;
   logic       out_rd_ff, out_rd_in;
   logic [1:0] out_cnt_ff, out_cnt_in;

   assign rsp_fire  = rsp_pop & ~rsp_empty;
   assign can_emit  = (out_cnt_ff != 2'd2) | rsp_fire;
   assign emit_fire = ~desc_empty & can_emit;
   assign is_chk    = (idx_ff == head_desc.count);

   // The running sum never wraps its 11 bits; its top bits are added to its low byte once.
   assign checksum = sum_ff[mcfb_pkg::BYTE_W-1:0]
                   + {{(2*mcfb_pkg::BYTE_W-mcfb_pkg::SUM_W){1'b0}},
                      sum_ff[mcfb_pkg::SUM_W-1:mcfb_pkg::BYTE_W]};

   always_comb begin
      emit_item.size_error = head_desc.size_error;
      emit_item.last_byte  = head_desc.size_error | is_chk;
      if (head_desc.size_error) begin
         emit_item.frame_byte = '0;
      end else if (is_chk) begin
         emit_item.frame_byte = checksum;
      end else begin
         emit_item.frame_byte = head_desc.bytes[idx_ff[2:0]];
      end
   end

   assign desc_pop = emit_fire & emit_item.last_byte;

   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      if (emit_fire) begin
         if (emit_item.last_byte) begin
            idx_in = '0;
            sum_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
            sum_in = sum_ff + {{(mcfb_pkg::SUM_W-mcfb_pkg::BYTE_W){1'b0}},
                               emit_item.frame_byte};
         end
      end
   end

   always_comb begin
      out_wr_in  = emit_fire ? ~out_wr_ff : out_wr_ff;
      out_rd_in  = rsp_fire  ? ~out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff + {1'b0, emit_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         sum_ff     <= '0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         idx_ff     <= idx_in;
         sum_ff     <= sum_in;
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         out_ff[out_wr_ff] <= emit_item;
      end
   end

   assign rsp_empty      = (out_cnt_ff == 2'd0);
   assign rsp_frame_byte = out_ff[out_rd_ff].frame_byte;
   assign rsp_last_byte  = out_ff[out_rd_ff].last_byte;
   assign rsp_size_error = out_ff[out_rd_ff].size_error;

   `MCFB_ASSERT_NEXT(a_idx_steps, clock, reset, emit_fire && !emit_item.last_byte, idx_ff == $past(idx_ff) + 1'b1)
   `MCFB_ASSERT_NEXT(a_idx_rewinds, clock, reset, emit_fire && emit_item.last_byte, idx_ff == '0 && sum_ff == '0)
   `MCFB_ASSERT_NOW(a_idx_bounded, clock, reset, !desc_empty, idx_ff <= head_desc.count || head_desc.size_error)
   `MCFB_ASSERT_NOW(a_error_alone, clock, reset, emit_fire && head_desc.size_error, idx_ff == '0 && desc_pop)

endmodule
